// ===== sv/smtc_pkg.sv =====
// shared types, codes and defaults for the scripted memory traffic core
`timescale 1ns / 1ps

package smtc_pkg;

  localparam int DEF_PROGRAM_DEPTH = 64;
  localparam int DEF_MAX_BYTES     = 8;

  localparam int NUM_STATS = 7;

  // input item kinds (s_tuser)
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // program op kinds
  localparam logic [1:0] OP_COMPUTE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_HALT    = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_INVALID_OP = 3'd1;
  localparam logic [2:0] ERR_BUSY       = 3'd2;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd3;
  localparam logic [2:0] ERR_REJECTED   = 3'd4;
  localparam logic [2:0] ERR_FULL       = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_HART_ID     = 2'd0;
  localparam logic [1:0] CFG_DEST_PORT   = 2'd1;
  localparam logic [1:0] CFG_STAT_SELECT = 2'd2;

  // statistics counter slots
  localparam int STAT_TICKS    = 0;
  localparam int STAT_COMPUTE  = 1;
  localparam int STAT_BLOCKED  = 2;
  localparam int STAT_SENT     = 3;
  localparam int STAT_WAIT     = 4;
  localparam int STAT_RECEIVED = 5;
  localparam int STAT_RETIRED  = 6;

  // one program store entry
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] latency;
    logic [63:0] address;
    logic [3:0]  size;
    logic [63:0] data;
  } prog_entry_t;

  localparam int ENTRY_W = $bits(prog_entry_t);

endpackage

// ===== sv/smtc_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module smtc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/scripted_memory_traffic_core.sv =====
// top level of the scripted memory traffic core
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser = kind, s_tdata = op and response fields
// m_*       out  m_tvalid/m_tready  m_tdata = request, state, error, read data, stat
// cfg_*     in   cfg_en             cfg_index selects the register, cfg_data is the value
//
// one result per input transfer; a transfer is taken every clock when the output
// register is empty or being drained, so the core runs at most one tick per cycle
// the result appears in the cycle after its input transfer, held in the output register
// the program lives in a ram with registered read; the entry at the head is always
// prefetched, a write to the slot being prefetched is forwarded through a bypass
// rst (synchronous) empties the program and clears state, counters and config
// a stall on m_tready holds the result and drops s_tready; nothing is lost

module scripted_memory_traffic_core
  import smtc_pkg::*;
#(
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  parameter int MAX_BYTES     = DEF_MAX_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // kind [1:0]
  input  logic [1:0]   s_tuser,
  // op_kind [1:0], op_latency [33:2], op_address [97:34], op_size [101:98],
  // op_data [165:102], send_ready [166], resp_valid [167], resp_hart [179:168],
  // resp_txn_id [211:180], resp_ok [212], resp_data [276:213], zero fill [279:277]
  input  logic [279:0] s_tdata,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // req_valid [0], req_is_write [1], req_txn_id [33:2], req_address [97:34],
  // req_size [101:98], req_data [165:102], core_state [168:166],
  // error_code [171:169], read_data [235:172], stat_value [299:236], zero fill [303:300]
  output logic [303:0] m_tdata,
  // configuration writes
  input  logic         cfg_en,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  localparam int PTR_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int CNT_W = $clog2(PROGRAM_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // core states
  localparam logic [2:0] ST_READY = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  function automatic logic [63:0] byte_mask(input logic [3:0] size);
    logic [63:0] m;
    if (size >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {size[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

  // input fields
  logic [1:0]  op_kind;
  logic [31:0] op_latency;
  logic [63:0] op_address;
  logic [3:0]  op_size;
  logic [63:0] op_data;
  logic        send_ready;
  logic        resp_valid;
  logic [11:0] resp_hart;
  logic [31:0] resp_txn_id;
  logic        resp_ok;
  logic [63:0] resp_data;

  assign op_kind     = s_tdata[1:0];
  assign op_latency  = s_tdata[33:2];
  assign op_address  = s_tdata[97:34];
  assign op_size     = s_tdata[101:98];
  assign op_data     = s_tdata[165:102];
  assign send_ready  = s_tdata[166];
  assign resp_valid  = s_tdata[167];
  assign resp_hart   = s_tdata[179:168];
  assign resp_txn_id = s_tdata[211:180];
  assign resp_ok     = s_tdata[212];
  assign resp_data   = s_tdata[276:213];

  // config registers; dest_port only steers the bus encoding, which is not built here
  logic [11:0] hart_id;
  logic [2:0]  stat_select;

  // core state
  logic [2:0]       mode, mode_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       cur_kind, cur_kind_next;
  logic [3:0]       cur_size, cur_size_next;
  logic [63:0]      cur_addr, cur_addr_next;
  logic [63:0]      cur_data, cur_data_next;
  logic [31:0]      lat_left, lat_left_next;
  logic [31:0]      next_txn, next_txn_next;
  logic [31:0]      wait_txn, wait_txn_next;
  logic [63:0]      last_read, last_read_next;
  logic [63:0]      stats [NUM_STATS];
  logic [63:0]      stats_next [NUM_STATS];
  logic [NUM_STATS-1:0] stat_inc;

  // program store and head prefetch
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  prog_entry_t      wr_entry;
  prog_entry_t      ram_q;
  logic             byp_hit;
  prog_entry_t      byp_entry;
  prog_entry_t      head_entry;
  logic [SUM_W-1:0] slot_sum;

  // step results
  logic        acc;
  logic [2:0]  err;
  logic        req_valid;
  logic        req_is_write;
  logic [31:0] req_txn_id;
  logic [63:0] req_address;
  logic [3:0]  req_size;
  logic [63:0] req_data;
  logic [63:0] stat_value;
  logic        op_is_mem;
  logic        op_invalid;

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  assign head_entry = byp_hit ? byp_entry : ram_q;

  // append slot is head + count, wrapped once
  always_comb begin
    slot_sum = SUM_W'(head) + SUM_W'(count);
    if (slot_sum >= SUM_W'(PROGRAM_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(PROGRAM_DEPTH);
    end
  end
  assign wr_addr = slot_sum[PTR_W-1:0];

  assign op_is_mem  = (op_kind == OP_READ) || (op_kind == OP_WRITE);
  assign op_invalid = ((op_kind == OP_COMPUTE) && (op_latency == 32'd0)) ||
                      (op_is_mem && ((op_latency == 32'd0) || (op_size == 4'd0) ||
                                     (op_size > 4'(MAX_BYTES))));

  always_comb begin
    wr_entry.kind    = op_kind;
    wr_entry.latency = (op_kind == OP_HALT) ? 32'd0 : op_latency;
    wr_entry.address = op_is_mem ? op_address : 64'd0;
    wr_entry.size    = op_is_mem ? op_size : 4'd0;
    wr_entry.data    = (op_kind == OP_WRITE) ? (op_data & byte_mask(op_size)) : 64'd0;
  end

  // one step of the core
  always_comb begin
    mode_next      = mode;
    head_next      = head;
    count_next     = count;
    cur_kind_next  = cur_kind;
    cur_size_next  = cur_size;
    cur_addr_next  = cur_addr;
    cur_data_next  = cur_data;
    lat_left_next  = lat_left;
    next_txn_next  = next_txn;
    wait_txn_next  = wait_txn;
    last_read_next = last_read;
    stat_inc       = '0;
    wr_en          = 1'b0;
    err            = ERR_NONE;
    req_valid      = 1'b0;
    req_is_write   = 1'b0;
    req_txn_id     = 32'd0;
    req_address    = 64'd0;
    req_size       = 4'd0;
    req_data       = 64'd0;

    if (acc) begin
      unique case (s_tuser)
        KIND_CLEAR: begin
          if (mode != ST_READY) begin
            err = ERR_BUSY;
          end else begin
            head_next  = '0;
            count_next = '0;
          end
        end
        KIND_APPEND: begin
          if (mode != ST_READY) begin
            err = ERR_BUSY;
          end else if (op_invalid) begin
            err = ERR_INVALID_OP;
          end else if (count == CNT_W'(PROGRAM_DEPTH)) begin
            err = ERR_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        KIND_TICK: begin
          if (mode != ST_HALT) begin
            stat_inc[STAT_TICKS] = 1'b1;
            if (mode == ST_WAIT) begin
              if (resp_valid) begin
                if ((resp_hart != hart_id) || (resp_txn_id != wait_txn)) begin
                  err = ERR_UNEXPECTED;
                end else begin
                  if (!resp_ok) begin
                    err = ERR_REJECTED;
                  end else if (cur_kind == OP_READ) begin
                    last_read_next = resp_data;
                  end
                  stat_inc[STAT_RECEIVED] = 1'b1;
                  stat_inc[STAT_RETIRED]  = 1'b1;
                  cur_kind_next = OP_COMPUTE;
                  cur_size_next = 4'd0;
                  cur_addr_next = 64'd0;
                  cur_data_next = 64'd0;
                  wait_txn_next = 32'd0;
                  mode_next     = ST_READY;
                end
              end
              if (mode_next == ST_WAIT) begin
                stat_inc[STAT_WAIT] = 1'b1;
              end
            end else begin
              // ready: pop the head op
              if (mode == ST_READY) begin
                if (count == '0) begin
                  mode_next = ST_HALT;
                end else begin
                  head_next  = (head == PTR_W'(PROGRAM_DEPTH - 1)) ? '0 : head + PTR_W'(1);
                  count_next = count - CNT_W'(1);
                  if (head_entry.kind == OP_HALT) begin
                    cur_kind_next = OP_COMPUTE;
                    cur_size_next = 4'd0;
                    cur_addr_next = 64'd0;
                    cur_data_next = 64'd0;
                    mode_next     = ST_HALT;
                  end else begin
                    cur_kind_next = head_entry.kind;
                    cur_size_next = head_entry.size;
                    cur_addr_next = head_entry.address;
                    cur_data_next = head_entry.data;
                    lat_left_next = head_entry.latency;
                    mode_next     = ST_EXEC;
                  end
                end
              end
              // executing: count down latency
              if (mode_next == ST_EXEC) begin
                if (lat_left_next != 32'd0) begin
                  lat_left_next          = lat_left_next - 32'd1;
                  stat_inc[STAT_COMPUTE] = 1'b1;
                end
                if (lat_left_next == 32'd0) begin
                  if (cur_kind_next == OP_COMPUTE) begin
                    stat_inc[STAT_RETIRED] = 1'b1;
                    cur_size_next = 4'd0;
                    cur_addr_next = 64'd0;
                    cur_data_next = 64'd0;
                    wait_txn_next = 32'd0;
                    mode_next     = ST_READY;
                  end else begin
                    mode_next = ST_ISSUE;
                  end
                end
              end
              // memory issue: send when the bus takes it
              if (mode_next == ST_ISSUE) begin
                if (!send_ready) begin
                  stat_inc[STAT_BLOCKED] = 1'b1;
                end else begin
                  req_valid    = 1'b1;
                  req_is_write = (cur_kind_next == OP_WRITE);
                  req_txn_id   = next_txn;
                  req_address  = cur_addr_next;
                  req_size     = cur_size_next;
                  req_data     = (cur_kind_next == OP_WRITE) ? cur_data_next : 64'd0;
                  wait_txn_next        = next_txn;
                  next_txn_next        = next_txn + 32'd1;
                  stat_inc[STAT_SENT]  = 1'b1;
                  mode_next            = ST_WAIT;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STATS; i++) begin
      stats_next[i] = stats[i] + 64'(stat_inc[i]);
    end
  end

  assign stat_value = (stat_select < 3'(NUM_STATS)) ? stats_next[stat_select] : 64'd0;

  smtc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PROGRAM_DEPTH),
    .ADDR_W(PTR_W)
  ) u_prog_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .raddr(head_next),
    .rdata(ram_q)
  );

  // forward a write that lands on the slot being prefetched
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= wr_en && (wr_addr == head_next);
    end
    byp_entry <= wr_entry;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hart_id     <= 12'd0;
      stat_select <= 3'd0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_HART_ID:     hart_id     <= cfg_data;
        CFG_STAT_SELECT: stat_select <= cfg_data[2:0];
        CFG_DEST_PORT: begin
          // port encoding not modelled, value has no effect
        end
        default: begin
        end
      endcase
    end
  end

  // core state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ST_READY;
      head      <= '0;
      count     <= '0;
      cur_kind  <= OP_COMPUTE;
      cur_size  <= 4'd0;
      cur_addr  <= 64'd0;
      cur_data  <= 64'd0;
      lat_left  <= 32'd0;
      next_txn  <= 32'd1;
      wait_txn  <= 32'd0;
      last_read <= 64'd0;
      for (int i = 0; i < NUM_STATS; i++) begin
        stats[i] <= 64'd0;
      end
    end else begin
      mode      <= mode_next;
      head      <= head_next;
      count     <= count_next;
      cur_kind  <= cur_kind_next;
      cur_size  <= cur_size_next;
      cur_addr  <= cur_addr_next;
      cur_data  <= cur_data_next;
      lat_left  <= lat_left_next;
      next_txn  <= next_txn_next;
      wait_txn  <= wait_txn_next;
      last_read <= last_read_next;
      for (int i = 0; i < NUM_STATS; i++) begin
        stats[i] <= stats_next[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (acc) begin
      m_tdata <= {4'd0, stat_value, last_read_next, err, mode_next, req_data, req_size,
                  req_address, req_txn_id, req_is_write, req_valid};
    end
  end

  // program never holds more ops than the store has slots
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(PROGRAM_DEPTH))
    else $error("program count above depth");

  // a clean append adds exactly one op
  assert property (@(posedge clk) disable iff (rst)
    acc && (s_tuser == KIND_APPEND) && (err == ERR_NONE)
      |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the program");

  // only reset leaves the halted state
  assert property (@(posedge clk) disable iff (rst) mode == ST_HALT |=> mode == ST_HALT)
    else $error("core left halt without reset");

  // a sent request always leaves the core waiting for its response
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[168:166] == ST_WAIT)
    else $error("request sent without entering memory wait");

endmodule
